// File: rtl/adaptive_arithmetic_encoder_assert.svh
// Assertion macros used by the encoder checker
`ifndef ADAPTIVE_ARITHMETIC_ENCODER_ASSERT_SVH
`define ADAPTIVE_ARITHMETIC_ENCODER_ASSERT_SVH

// same-cycle implication
`define AAE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define AAE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/aae_pkg.sv
// Package: widths, codes and control types of the arithmetic encoder
`timescale 1ns / 1ps
package aae_pkg;
   localparam int DEF_CODE_BITS     = 16;
   localparam int DEF_ALPHABET_SIZE = 257;

   localparam int COUNT_W   = 14;
   localparam int PEND_W    = 16;
   localparam int SYM_IN_W  = 9;
   localparam int INC_W     = 8;
   localparam int CSR_W     = 14;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 14'h3FFF;
   localparam logic [PEND_W-1:0]  PEND_MAX   = 16'hFFFF;
   localparam logic [COUNT_W-1:0] THR_RESET  = 14'd16383;
   localparam logic [INC_W-1:0]   INC_RESET  = 8'd32;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INCREMENT = 1'd1;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic rd_sym;
      logic rd_next;
      logic cap_lo;
      logic mul_hi;
      logic mul_lo;
      logic div_start;
      logic cap_q_hi;
      logic narrow;
      logic renorm;
      logic flush;
      logic finish;
      logic model_start;
      logic halve_rd;
      logic halve_wr;
      logic inc_prep;
      logic inc_rd;
      logic inc_wr;
   } aae_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_finish;
      logic sym_bad;
      logic div_busy;
      logic renorm_stop;
      logic held_valid;
      logic push_ok;
      logic halve_need;
      logic walk_zero;
   } aae_status_type;
endpackage

// File: rtl/aae_if.sv
// Channel interfaces: symbol requests and code-bit responses
`timescale 1ns / 1ps
interface aae_req_if import aae_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SYM_IN_W-1:0] symbol;
   modport source (output valid, cmd, symbol, input ready);
   modport sink   (input valid, cmd, symbol, output ready);
endinterface

interface aae_rsp_if import aae_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              code_bit;
   logic [PEND_W-1:0] follow_count;
   logic              last;
   modport source (output valid, code_bit, follow_count, last, input ready);
   modport sink   (input valid, code_bit, follow_count, last, output ready);
endinterface

// File: rtl/adaptive_arithmetic_encoder.sv
// Adaptive order-0 arithmetic encoder, top level
`timescale 1ns / 1ps
// Usage: send items on req_ch (cmd 0 = encode symbol, cmd 1 = finish).
// Each code bit comes out on rsp_ch with the count of inverted follow bits;
// last marks the final bit caused by one item. csr_we writes register
// csr_index (0 threshold, 1 increment); the user must do so only while the
// block is idle, which the block itself does not enforce. One item at a time:
// req_ch.ready is high only between items. Encode: two serial divisions,
// then renormalization steps, then the cumulative-count update walks from
// the symbol down to entry 0 through the count RAM; a rescale first walks
// every entry. Out-of-alphabet symbols are dropped with no output. Finish:
// the final bit, then a clearing pass over all ALPHABET_SIZE+1 entries.
// After reset the same clearing pass runs before the first item is taken;
// configuration writes are taken throughout.
// A stalled receiver holds the output register and one staged bit;
// renormalization waits until a bit can move on.
module adaptive_arithmetic_encoder import aae_pkg::*; #(
   parameter int CODE_BITS     = DEF_CODE_BITS,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   aae_req_if.sink              req_ch,
   aae_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   aae_cmd_type    cmd;
   aae_status_type status;

   aae_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_ch.valid),
      .req_ready(req_ch.ready), .status(status), .cmd(cmd)
   );

   aae_dp #(.CODE_BITS(CODE_BITS), .ALPHABET_SIZE(ALPHABET_SIZE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_cmd(req_ch.cmd), .req_symbol(req_ch.symbol),
      .rsp_ready(rsp_ch.ready), .rsp_valid(rsp_ch.valid),
      .rsp_code_bit(rsp_ch.code_bit), .rsp_follow_count(rsp_ch.follow_count),
      .rsp_last(rsp_ch.last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );
endmodule

// File: rtl/aae_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module aae_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/aae_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module aae_div import aae_pkg::*; #(
   parameter int DVD_W = 31
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               busy,
   output logic [DVD_W-1:0]   quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] dsr_ff, dsr_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = COUNT_W'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[COUNT_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// File: rtl/aae_dp.sv
// Datapath: interval, frequency table, divider and result registers
`timescale 1ns / 1ps
module aae_dp import aae_pkg::*; #(
   parameter int CODE_BITS     = DEF_CODE_BITS,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aae_cmd_type          cmd,
   output aae_status_type       status,
   input  logic                 req_cmd,
   input  logic [SYM_IN_W-1:0]  req_symbol,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_code_bit,
   output logic [PEND_W-1:0]    rsp_follow_count,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   localparam int SYM_W  = $clog2(ALPHABET_SIZE + 1);
   localparam int DVD_W  = CODE_BITS + 1 + COUNT_W;
   localparam int STEP_W = $clog2(CODE_BITS + 1);
   localparam logic [CODE_BITS-1:0] HALF = {1'b1, {(CODE_BITS-1){1'b0}}};
   localparam logic [CODE_BITS-1:0] Q1   = {2'b01, {(CODE_BITS-2){1'b0}}};
   localparam logic [CODE_BITS-1:0] Q3   = {2'b11, {(CODE_BITS-2){1'b0}}};
   localparam logic [SYM_W-1:0]     LAST_IDX = SYM_W'(ALPHABET_SIZE);
   localparam logic [SYM_W-1:0]     TOP_SYM  = SYM_W'(ALPHABET_SIZE - 1);

   logic [COUNT_W-1:0]   thr_ff, thr_in;
   logic [INC_W-1:0]     inc_cfg_ff, inc_cfg_in;
   logic [CODE_BITS-1:0] low_ff, low_in, high_ff, high_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;
   logic                 fin_ff, fin_in, bad_ff, bad_in;
   logic [COUNT_W-1:0]   cum_hi_ff, cum_hi_in, cum_lo_ff, cum_lo_in;
   logic [DVD_W-1:0]     prod_ff, prod_in;
   logic [CODE_BITS:0]   q_hi_ff, q_hi_in;
   logic [SYM_W-1:0]     idx_ff, idx_in;
   logic [COUNT_W-1:0]   prev_ff, prev_in, acc_ff, acc_in, inc_ff, inc_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 held_valid_ff, held_valid_in, held_bit_ff, held_bit_in;
   logic [PEND_W-1:0]    held_follow_ff, held_follow_in;
   logic                 out_valid_ff, out_valid_in, out_bit_ff, out_bit_in;
   logic                 out_last_ff, out_last_in;
   logic [PEND_W-1:0]    out_follow_ff, out_follow_in;

   logic                 ram_we, ram_re;
   logic [SYM_W-1:0]     ram_wa, ram_ra;
   logic [COUNT_W-1:0]   ram_wd, ram_rd;
   logic                 div_busy;
   logic [DVD_W-1:0]     div_q;
   logic [COUNT_W-1:0]   divisor;

   logic [CODE_BITS:0]   range, nl, nh_raw, nh;
   logic                 e0, e1, e2, stop, push_ok;
   logic [CODE_BITS-1:0] low_sub, high_sub;
   logic [PEND_W-1:0]    pend_inc;
   logic [31:0]          sym32;
   logic [COUNT_W-1:0]   diff, half_cnt, acc_new, room;
   logic [COUNT_W:0]     diff_p1;

   aae_ram #(.WIDTH(COUNT_W), .DEPTH(ALPHABET_SIZE + 1)) u_cum (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_en(ram_re), .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign divisor = (total_ff == '0) ? COUNT_W'(1) : total_ff;

   aae_div #(.DVD_W(DVD_W)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(prod_ff),
      .divisor(divisor), .busy(div_busy), .quotient(div_q)
   );

   always_comb begin
      range    = {1'b0, high_ff} - {1'b0, low_ff} + 1'b1;
      e0       = high_ff < HALF;
      e1       = low_ff >= HALF;
      e2       = (low_ff >= Q1) && (high_ff < Q3);
      stop     = (!e0 && !e1 && !e2) || (step_ff == STEP_W'(CODE_BITS));
      push_ok  = !out_valid_ff || rsp_ready;
      pend_inc = (pend_ff == PEND_MAX) ? pend_ff : pend_ff + 1'b1;
      sym32    = 32'(req_symbol);
      nl       = {1'b0, low_ff} + div_q[CODE_BITS:0];
      nh_raw   = {1'b0, low_ff} + q_hi_ff;
      nh       = (nh_raw == '0) ? '0 : nh_raw - 1'b1;
      if (nh < nl) begin
         nh = nl;
      end
      if (e0) begin
         low_sub  = low_ff;
         high_sub = high_ff;
      end else if (e1) begin
         low_sub  = low_ff - HALF;
         high_sub = high_ff - HALF;
      end else begin
         low_sub  = low_ff - Q1;
         high_sub = high_ff - Q1;
      end
      diff     = ram_rd - prev_ff;
      diff_p1  = {1'b0, diff} + 1'b1;
      half_cnt = diff_p1[COUNT_W:1];
      acc_new  = acc_ff + half_cnt;
      room     = COUNT_MAX - total_ff;
   end

   always_comb begin
      thr_in         = thr_ff;
      inc_cfg_in     = inc_cfg_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      pend_in        = pend_ff;
      total_in       = total_ff;
      sym_in         = sym_ff;
      fin_in         = fin_ff;
      bad_in         = bad_ff;
      cum_hi_in      = cum_hi_ff;
      cum_lo_in      = cum_lo_ff;
      prod_in        = prod_ff;
      q_hi_in        = q_hi_ff;
      idx_in         = idx_ff;
      prev_in        = prev_ff;
      acc_in         = acc_ff;
      inc_in         = inc_ff;
      step_in        = step_ff;
      held_valid_in  = held_valid_ff;
      held_bit_in    = held_bit_ff;
      held_follow_in = held_follow_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_bit_in     = out_bit_ff;
      out_follow_in  = out_follow_ff;
      out_last_in    = out_last_ff;
      ram_we         = 1'b0;
      ram_wa         = idx_ff;
      ram_wd         = ram_rd;
      ram_re         = 1'b0;
      ram_ra         = idx_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD: thr_in     = csr_wdata[COUNT_W-1:0];
            REG_INCREMENT: inc_cfg_in = csr_wdata[INC_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         sym_in = sym32[SYM_W-1:0];
         fin_in = req_cmd;
         bad_in = sym32 >= 32'(ALPHABET_SIZE);
      end

      if (cmd.clear_step) begin
         ram_we = 1'b1;
         ram_wd = COUNT_W'(ALPHABET_SIZE) - COUNT_W'(idx_ff);
         if (idx_ff == LAST_IDX) begin
            idx_in   = '0;
            total_in = COUNT_W'(ALPHABET_SIZE);
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (cmd.rd_sym) begin
         ram_re = 1'b1;
         ram_ra = sym_ff;
      end
      if (cmd.rd_next) begin
         ram_re    = 1'b1;
         ram_ra    = sym_ff + 1'b1;
         cum_hi_in = ram_rd;
      end
      if (cmd.cap_lo) begin
         cum_lo_in = ram_rd;
      end
      if (cmd.mul_hi) begin
         prod_in = {{COUNT_W{1'b0}}, range} * {{(CODE_BITS+1){1'b0}}, cum_hi_ff};
      end
      if (cmd.mul_lo) begin
         prod_in = {{COUNT_W{1'b0}}, range} * {{(CODE_BITS+1){1'b0}}, cum_lo_ff};
      end
      if (cmd.cap_q_hi) begin
         q_hi_in = div_q[CODE_BITS:0];
      end
      if (cmd.narrow) begin
         low_in  = nl[CODE_BITS-1:0];
         high_in = nh[CODE_BITS-1:0];
         step_in = '0;
      end

      if (cmd.renorm && !stop) begin
         if ((e0 || e1) && held_valid_ff && !push_ok) begin
            // hold: the earlier bit still has nowhere to go
         end else begin
            if (e0 || e1) begin
               if (held_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_bit_in    = held_bit_ff;
                  out_follow_in = held_follow_ff;
                  out_last_in   = 1'b0;
               end
               held_valid_in  = 1'b1;
               held_bit_in    = e1;
               held_follow_in = pend_ff;
               pend_in        = '0;
            end else begin
               pend_in = pend_inc;
            end
            low_in  = {low_sub[CODE_BITS-2:0], 1'b0};
            high_in = {high_sub[CODE_BITS-2:0], 1'b1};
            step_in = step_ff + 1'b1;
         end
      end

      if (cmd.finish) begin
         held_valid_in  = 1'b1;
         held_bit_in    = !(low_ff < Q1);
         held_follow_in = pend_inc;
         low_in         = '0;
         high_in        = '1;
         pend_in        = '0;
         idx_in         = '0;
      end

      if (cmd.flush && held_valid_ff && push_ok) begin
         out_valid_in  = 1'b1;
         out_bit_in    = held_bit_ff;
         out_follow_in = held_follow_ff;
         out_last_in   = 1'b1;
         held_valid_in = 1'b0;
      end

      if (cmd.model_start) begin
         idx_in  = TOP_SYM;
         prev_in = '0;
         acc_in  = '0;
      end
      if (cmd.halve_rd || cmd.inc_rd) begin
         ram_re = 1'b1;
      end
      if (cmd.halve_wr) begin
         // rebuild cumulative from the top down with rounded-up halves
         ram_we  = 1'b1;
         ram_wd  = acc_new;
         prev_in = ram_rd;
         acc_in  = acc_new;
         if (idx_ff == '0) begin
            total_in = acc_new;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (cmd.inc_prep) begin
         if (total_ff >= COUNT_MAX) begin
            inc_in = '0;
         end else if (COUNT_W'(inc_cfg_ff) > room) begin
            inc_in = room;
         end else begin
            inc_in = COUNT_W'(inc_cfg_ff);
         end
         idx_in = sym_ff;
      end
      if (cmd.inc_wr) begin
         ram_we = 1'b1;
         ram_wd = ram_rd + inc_ff;
         if (idx_ff == '0) begin
            total_in = total_ff + inc_ff;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THR_RESET;
         inc_cfg_ff    <= INC_RESET;
         low_ff        <= '0;
         high_ff       <= '1;
         pend_ff       <= '0;
         idx_ff        <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         thr_ff        <= thr_in;
         inc_cfg_ff    <= inc_cfg_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      total_ff       <= total_in;
      sym_ff         <= sym_in;
      fin_ff         <= fin_in;
      bad_ff         <= bad_in;
      cum_hi_ff      <= cum_hi_in;
      cum_lo_ff      <= cum_lo_in;
      prod_ff        <= prod_in;
      q_hi_ff        <= q_hi_in;
      prev_ff        <= prev_in;
      acc_ff         <= acc_in;
      inc_ff         <= inc_in;
      step_ff        <= step_in;
      held_bit_ff    <= held_bit_in;
      held_follow_ff <= held_follow_in;
      out_bit_ff     <= out_bit_in;
      out_follow_ff  <= out_follow_in;
      out_last_ff    <= out_last_in;
   end

   assign status.clear_last  = idx_ff == LAST_IDX;
   assign status.is_finish   = fin_ff;
   assign status.sym_bad     = bad_ff;
   assign status.div_busy    = div_busy;
   assign status.renorm_stop = stop;
   assign status.held_valid  = held_valid_ff;
   assign status.push_ok     = push_ok;
   assign status.halve_need  = total_ff >= thr_ff;
   assign status.walk_zero   = idx_ff == '0;

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_bit     = out_bit_ff;
   assign rsp_follow_count = out_follow_ff;
   assign rsp_last         = out_last_ff;
endmodule

// File: rtl/aae_ctrl.sv
// Controller: sequences reads, divisions, renormalization and model walks
`timescale 1ns / 1ps
module aae_ctrl import aae_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  aae_status_type status,
   output aae_cmd_type    cmd
);
   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_DISPATCH = 5'd2;
   localparam logic [4:0] S_RD_LO    = 5'd3;
   localparam logic [4:0] S_CAP_LO   = 5'd4;
   localparam logic [4:0] S_MUL_HI   = 5'd5;
   localparam logic [4:0] S_DIV_HI   = 5'd6;
   localparam logic [4:0] S_WAIT_HI  = 5'd7;
   localparam logic [4:0] S_MUL_LO   = 5'd8;
   localparam logic [4:0] S_DIV_LO   = 5'd9;
   localparam logic [4:0] S_WAIT_LO  = 5'd10;
   localparam logic [4:0] S_RENORM   = 5'd11;
   localparam logic [4:0] S_FLUSH    = 5'd12;
   localparam logic [4:0] S_MODEL    = 5'd13;
   localparam logic [4:0] S_HALVE_RD = 5'd14;
   localparam logic [4:0] S_HALVE_WR = 5'd15;
   localparam logic [4:0] S_INC_PREP = 5'd16;
   localparam logic [4:0] S_INC_RD   = 5'd17;
   localparam logic [4:0] S_INC_WR   = 5'd18;
   localparam logic [4:0] S_FINISH   = 5'd19;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_finish) begin
               state_in = S_FINISH;
            end else if (status.sym_bad) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_sym = 1'b1;
               state_in   = S_RD_LO;
            end
         end
         S_RD_LO: begin
            cmd.rd_next = 1'b1;
            state_in    = S_CAP_LO;
         end
         S_CAP_LO: begin
            cmd.cap_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DIV_HI;
         end
         S_DIV_HI: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT_HI;
         end
         S_WAIT_HI: begin
            if (!status.div_busy) begin
               cmd.cap_q_hi = 1'b1;
               state_in     = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_DIV_LO;
         end
         S_DIV_LO: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT_LO;
         end
         S_WAIT_LO: begin
            if (!status.div_busy) begin
               cmd.narrow = 1'b1;
               state_in   = S_RENORM;
            end
         end
         S_RENORM: begin
            cmd.renorm = 1'b1;
            if (status.renorm_stop) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (!status.held_valid || status.push_ok) begin
               state_in = status.is_finish ? S_CLEAR : S_MODEL;
            end
         end
         S_MODEL: begin
            cmd.model_start = 1'b1;
            state_in        = status.halve_need ? S_HALVE_RD : S_INC_PREP;
         end
         S_HALVE_RD: begin
            cmd.halve_rd = 1'b1;
            state_in     = S_HALVE_WR;
         end
         S_HALVE_WR: begin
            cmd.halve_wr = 1'b1;
            state_in     = status.walk_zero ? S_INC_PREP : S_HALVE_RD;
         end
         S_INC_PREP: begin
            cmd.inc_prep = 1'b1;
            state_in     = S_INC_RD;
         end
         S_INC_RD: begin
            cmd.inc_rd = 1'b1;
            state_in   = S_INC_WR;
         end
         S_INC_WR: begin
            cmd.inc_wr = 1'b1;
            state_in   = status.walk_zero ? S_IDLE : S_INC_RD;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_FLUSH;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
endmodule

// File: rtl/aae_checker.sv
// Port-level checks for the arithmetic encoder, bound to the top level
`timescale 1ns / 1ps
`include "adaptive_arithmetic_encoder_assert.svh"
module aae_checker import aae_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_code_bit,
   input logic [PEND_W-1:0] rsp_follow_count,
   input logic              rsp_last
);
   // clearing pass follows reset
   `AAE_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !req_ready)
   // one item at a time
   `AAE_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   // a result still waiting when a new item is taken closes the previous item
   `AAE_ASSERT_IMP(a_idle_last, clock, reset, req_valid && req_ready && rsp_valid, rsp_last)
   `AAE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_code_bit) && $stable(rsp_follow_count) && $stable(rsp_last))
endmodule

bind adaptive_arithmetic_encoder aae_checker u_aae_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_code_bit(rsp_ch.code_bit), .rsp_follow_count(rsp_ch.follow_count),
   .rsp_last(rsp_ch.last)
);

// File: dv/tb_adaptive_arithmetic_encoder.sv
// Testbench for the adaptive arithmetic encoder: random symbol streams checked bit for bit
`timescale 1ns / 1ps
module tb_adaptive_arithmetic_encoder;
   import aae_pkg::*;

   localparam int NSYM      = DEF_ALPHABET_SIZE;
   localparam int CBITS     = DEF_CODE_BITS;
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FINISH = 1'b1;
   localparam longint CODE_MASK = (64'd1 << CBITS) - 1;
   localparam longint HALF_PT   = 64'd1 << (CBITS - 1);
   localparam longint Q1_PT     = 64'd1 << (CBITS - 2);
   localparam longint Q3_PT     = 3 * Q1_PT;
   localparam int DRAIN_CYCLES  = 3000;

   typedef struct packed {
      logic                cmd;
      logic [SYM_IN_W-1:0] symbol;
   } sym_item_type;

   typedef struct packed {
      logic              code_bit;
      logic [PEND_W-1:0] follow_count;
      logic              last;
   } code_bit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   aae_req_if req_ch ();
   aae_rsp_if rsp_ch ();

   adaptive_arithmetic_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   sym_item_type pending_items[$];
   code_bit_type expected_bits[$];
   int errors = 0;
   int n_items = 0;
   int n_bits = 0;
   int n_finish = 0;
   int cyc = 0;
   logic req_taken = 1'b0;

   // encoder model state
   int unsigned thresh_q = THR_RESET;
   int unsigned incr_q = INC_RESET;
   longint lo_q, hi_q;
   int unsigned follow_q;
   int unsigned freq_q [NSYM];
   int unsigned cum_q [NSYM+1];

   function automatic void clear_coder();
      lo_q = 0;
      hi_q = CODE_MASK;
      follow_q = 0;
      for (int j = 0; j < NSYM; j++) freq_q[j] = 1;
      for (int j = 0; j <= NSYM; j++) cum_q[j] = NSYM - j;
   endfunction

   function automatic void push_bit(logic b, ref int n);
      code_bit_type e;
      if (n < 17) begin
         e.code_bit = b;
         e.follow_count = follow_q[15:0];
         e.last = 1'b0;
         expected_bits = {expected_bits, e};
         n++;
      end
      follow_q = 0;
   endfunction

   function automatic void adapt_model(int s);
      int unsigned acc, inc;
      if (cum_q[0] >= thresh_q) begin
         acc = 0;
         cum_q[NSYM] = 0;
         for (int i = NSYM - 1; i >= 0; i--) begin
            freq_q[i] = (freq_q[i] + 1) / 2;
            acc += freq_q[i];
            cum_q[i] = acc;
         end
      end
      inc = incr_q;
      if (cum_q[0] >= COUNT_MAX) inc = 0;
      else if (inc > COUNT_MAX - cum_q[0]) inc = COUNT_MAX - cum_q[0];
      freq_q[s] += inc;
      for (int i = s; i >= 0; i--) cum_q[i] += inc;
   endfunction

   function automatic void encode_item(logic cmd, logic [SYM_IN_W-1:0] symbol);
      int n;
      int s;
      longint range, total, nh, nl;
      code_bit_type e;
      n = 0;
      if (cmd == CMD_FINISH) begin
         if (follow_q < PEND_MAX) follow_q++;
         push_bit(lo_q < Q1_PT ? 1'b0 : 1'b1, n);
         clear_coder();
      end else begin
         s = symbol;
         if (s >= NSYM) return;
         total = cum_q[0];
         if (total == 0) total = 1;
         range = hi_q - lo_q + 1;
         nh = lo_q + (range * cum_q[s]) / total;
         nl = lo_q + (range * cum_q[s+1]) / total;
         nh = (nh == 0) ? 0 : nh - 1;
         if (nh < nl) nh = nl;
         lo_q = nl & CODE_MASK;
         hi_q = nh & CODE_MASK;
         for (int st = 0; st < CBITS; st++) begin
            if (hi_q < HALF_PT) begin
               push_bit(1'b0, n);
            end else if (lo_q >= HALF_PT) begin
               push_bit(1'b1, n);
               lo_q -= HALF_PT;
               hi_q -= HALF_PT;
            end else if (lo_q >= Q1_PT && hi_q < Q3_PT) begin
               if (follow_q < PEND_MAX) follow_q++;
               lo_q -= Q1_PT;
               hi_q -= Q1_PT;
            end else begin
               break;
            end
            lo_q = (lo_q << 1) & CODE_MASK;
            hi_q = ((hi_q << 1) | 1) & CODE_MASK;
         end
         adapt_model(s);
      end
      if (n > 0) begin
         e = expected_bits.pop_back();
         e.last = 1'b1;
         expected_bits = {expected_bits, e};
      end
   endfunction

   function automatic logic quiet_now();
      return cyc >= 20000 && cyc < 60000;
   endfunction

   // sample at the rising edge: request transfers, config writes, response checks
   always @(posedge clock) begin
      code_bit_type e;
      cyc <= cyc + 1;
      if (reset) begin
         clear_coder();
         thresh_q = THR_RESET;
         incr_q = INC_RESET;
         req_taken <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_THRESHOLD) thresh_q = csr_wdata;
            else if (csr_index == REG_INCREMENT) incr_q = csr_wdata[INC_W-1:0];
         end
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            n_items++;
            if (req_ch.cmd == CMD_FINISH) n_finish++;
            encode_item(req_ch.cmd, req_ch.symbol);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_bits++;
            if (expected_bits.size() == 0) begin
               $error("unexpected code bit %0d", rsp_ch.code_bit);
               errors++;
            end else begin
               e = expected_bits.pop_front();
               if (rsp_ch.code_bit !== e.code_bit) begin
                  $error("code_bit expected %0d actual %0d", e.code_bit, rsp_ch.code_bit);
                  errors++;
               end
               if (rsp_ch.follow_count !== e.follow_count) begin
                  $error("follow_count expected %0d actual %0d",
                         e.follow_count, rsp_ch.follow_count);
                  errors++;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_ch.last);
                  errors++;
               end
            end
         end
      end
   end

   // drive at the falling edge
   always @(negedge clock) begin
      sym_item_type it;
      logic nv;
      logic [SYM_IN_W-1:0] ns;
      logic nc;
      nv = req_ch.valid;
      nc = req_ch.cmd;
      ns = req_ch.symbol;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_items.size() > 0 && (quiet_now() || $urandom_range(99) >= 10)) begin
            it = pending_items.pop_front();
            nv = 1'b1;
            nc = it.cmd;
            ns = it.symbol;
         end else begin
            nv = 1'b0;
         end
      end
      req_ch.valid <= nv;
      req_ch.cmd <= nc;
      req_ch.symbol <= ns;
      rsp_ch.ready <= !reset && (quiet_now() || $urandom_range(99) >= 10);
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_ENCODE;
      req_ch.symbol = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic add_item(logic cmd, int symbol);
      sym_item_type it;
      it.cmd = cmd;
      it.symbol = symbol[SYM_IN_W-1:0];
      pending_items = {pending_items, it};
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until the block is idle, then allow for a trailing item with no result
   task automatic drain();
      while (pending_items.size() > 0 || req_ch.valid || expected_bits.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_stream(int count, int hot_span);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 7) add_item(CMD_FINISH, $urandom_range(511));
         else if (r < 11) add_item(CMD_ENCODE, $urandom_range(511, NSYM));
         else if (r < 70) add_item(CMD_ENCODE, $urandom_range(hot_span));
         else add_item(CMD_ENCODE, $urandom_range(NSYM - 1));
      end
      add_item(CMD_FINISH, $urandom_range(511));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, sentinel, ignored symbols, finish
      add_item(CMD_ENCODE, 0);
      add_item(CMD_ENCODE, NSYM - 1);
      add_item(CMD_ENCODE, NSYM - 2);
      add_item(CMD_ENCODE, 1);
      add_item(CMD_ENCODE, NSYM);
      add_item(CMD_ENCODE, 511);
      add_item(CMD_FINISH, 0);
      add_item(CMD_FINISH, 511);
      for (int k = 0; k < 8; k++) add_item(CMD_ENCODE, 3);
      add_item(CMD_FINISH, NSYM - 1);
      drain();

      // rescale on every item, largest increment
      write_reg(REG_THRESHOLD, 2);
      write_reg(REG_INCREMENT, 255);
      for (int k = 0; k < 6; k++) add_item(CMD_ENCODE, 0);
      random_stream(80, 3);
      drain();

      // largest threshold with largest increment: total saturates
      write_reg(REG_THRESHOLD, 16383);
      random_stream(90, 1);
      drain();

      // small increment and moderate threshold
      write_reg(REG_THRESHOLD, 300);
      write_reg(REG_INCREMENT, 1);
      random_stream(90, 15);
      drain();

      write_reg(REG_THRESHOLD, 1000);
      write_reg(REG_INCREMENT, 32);
      random_stream(90, 7);
      drain();

      $display("covered %0d items (%0d finishes), %0d code bits checked",
               n_items, n_finish, n_bits);
      if (errors == 0 && expected_bits.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d bits outstanding", errors, expected_bits.size());
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("timeout");
      $display("tb: failure");
      $finish;
   end
endmodule

// File: adaptive_arithmetic_encoder.f
+incdir+rtl
rtl/aae_pkg.sv
rtl/aae_if.sv
rtl/aae_ram.sv
rtl/aae_div.sv
rtl/aae_dp.sv
rtl/aae_ctrl.sv
rtl/adaptive_arithmetic_encoder.sv
rtl/aae_checker.sv
dv/tb_adaptive_arithmetic_encoder.sv
